// ===== hdl/nlsc_pkg.sv =====
// shared types and constants for the length-prefix to start-code converter
`default_nettype none

package nlsc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 32;
  localparam int unsigned SizeW  = 3;
  localparam int unsigned SeenW  = 2;
  localparam int unsigned UserW  = 5;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // prefix size limits
  localparam logic [SizeW-1:0] SizeMin   = 3'd1;
  localparam logic [SizeW-1:0] SizeMax   = 3'd4;
  localparam logic [SizeW-1:0] SizeReset = 3'd4;

  // start code: three zero bytes then a one
  localparam logic [ByteW-1:0] ScZero = 8'h00;
  localparam logic [ByteW-1:0] ScOne  = 8'h01;
  localparam logic [1:0]       ScTail = 2'd3;

  // register indexes
  typedef enum logic {
    REG_LENGTH_FIELD_BYTES = 1'b0,
    REG_FRAGMENT_MODE      = 1'b1
  } nlsc_reg_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_IN_PREFIX  = 2'd1,
    STATUS_IN_PAYLOAD = 2'd2
  } nlsc_status_e;

  // what one accepted word produces
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ONE   = 2'd1,
    ACT_START = 2'd2
  } nlsc_act_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             has_byte;
    logic             unit_end;
    logic             sample_end;
    nlsc_status_e     status;
  } nlsc_res_t;

endpackage

`default_nettype wire

// ===== hdl/nlsc_parse.sv =====
// prefix and payload tracking: state registers and per-word decision logic
`default_nettype none

module nlsc_parse (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic [nlsc_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                       last_i,
  input  wire logic [nlsc_pkg::SizeW-1:0] size_cfg_i,
  input  wire logic                       fragment_mode_i,
  output nlsc_pkg::nlsc_act_e             act_o,
  output nlsc_pkg::nlsc_res_t             res_o
);

  logic                       in_payload_q, in_payload_d;
  logic [nlsc_pkg::SeenW-1:0] seen_q, seen_d;
  logic [nlsc_pkg::LenW-1:0]  accum_q, accum_d;
  logic [nlsc_pkg::LenW-1:0]  rem_q, rem_d;

  logic [nlsc_pkg::SizeW-1:0] size;
  logic [nlsc_pkg::SizeW-1:0] seen_inc;
  logic [nlsc_pkg::LenW-1:0]  accum_next;
  logic [nlsc_pkg::LenW-1:0]  rem_dec;

  // out-of-range sizes clamp to the nearest legal one
  always_comb begin
    if (size_cfg_i < nlsc_pkg::SizeMin) begin
      size = nlsc_pkg::SizeMin;
    end else if (size_cfg_i > nlsc_pkg::SizeMax) begin
      size = nlsc_pkg::SizeMax;
    end else begin
      size = size_cfg_i;
    end
  end

  assign seen_inc   = {1'b0, seen_q} + nlsc_pkg::SizeW'(1);
  assign accum_next = {accum_q[nlsc_pkg::LenW-nlsc_pkg::ByteW-1:0], in_byte_i};
  assign rem_dec    = rem_q - nlsc_pkg::LenW'(1);

  always_comb begin
    in_payload_d = in_payload_q;
    seen_d       = seen_q;
    accum_d      = accum_q;
    rem_d        = rem_q;
    act_o        = nlsc_pkg::ACT_NONE;
    res_o        = '0;
    if (in_payload_q) begin
      rem_d          = rem_dec;
      act_o          = nlsc_pkg::ACT_ONE;
      res_o.out_byte = in_byte_i;
      res_o.has_byte = 1'b1;
      if (rem_dec == '0) begin
        res_o.unit_end   = 1'b1;
        res_o.sample_end = last_i;
        in_payload_d     = 1'b0;
        seen_d           = '0;
        accum_d          = '0;
      end else if (last_i) begin
        // sample cut short inside a payload
        res_o.unit_end   = 1'b1;
        res_o.sample_end = 1'b1;
        res_o.status     = nlsc_pkg::STATUS_IN_PAYLOAD;
        in_payload_d     = 1'b0;
        seen_d           = '0;
        accum_d          = '0;
        rem_d            = '0;
      end
    end else begin
      accum_d = accum_next;
      if (seen_inc >= size) begin
        accum_d = '0;
        seen_d  = '0;
        if (accum_next == '0) begin
          // empty unit: marker in fragment mode, else dropped unless it ends the sample
          if (fragment_mode_i) begin
            act_o            = nlsc_pkg::ACT_ONE;
            res_o.unit_end   = 1'b1;
            res_o.sample_end = last_i;
          end else if (last_i) begin
            act_o            = nlsc_pkg::ACT_ONE;
            res_o.sample_end = 1'b1;
          end
        end else if (last_i) begin
          // prefix complete but no payload follows
          act_o            = nlsc_pkg::ACT_ONE;
          res_o.unit_end   = 1'b1;
          res_o.sample_end = 1'b1;
          res_o.status     = nlsc_pkg::STATUS_IN_PAYLOAD;
          rem_d            = '0;
        end else begin
          in_payload_d = 1'b1;
          rem_d        = accum_next;
          if (!fragment_mode_i) begin
            act_o          = nlsc_pkg::ACT_START;
            res_o.out_byte = nlsc_pkg::ScZero;
            res_o.has_byte = 1'b1;
          end
        end
      end else if (last_i) begin
        act_o            = nlsc_pkg::ACT_ONE;
        res_o.sample_end = 1'b1;
        res_o.status     = nlsc_pkg::STATUS_IN_PREFIX;
        seen_d           = '0;
        accum_d          = '0;
        rem_d            = '0;
      end else begin
        seen_d = seen_inc[nlsc_pkg::SeenW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      seen_q       <= '0;
      accum_q      <= '0;
      rem_q        <= '0;
    end else if (step_i) begin
      in_payload_q <= in_payload_d;
      seen_q       <= seen_d;
      accum_q      <= accum_d;
      rem_q        <= rem_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/nal_length_prefix_to_start_code.sv =====
// top level: length-prefixed units in, start-code or bare fragment units out
`default_nettype none

// Converts a sample made of length-prefixed units (big-endian prefix of 1 to
// 4 bytes, set by length_field_bytes) into a byte stream. With fragment_mode
// clear, every non-empty unit goes out behind 00 00 00 01 and empty units are
// dropped; with it set, payloads go out bare, the last word of each unit
// carries unit_end and an empty unit gives a marker word (has_byte low).
// Samples that end early are flagged in status rather than rejected. Rate:
// one input word per cycle unless the output stalls; a word that completes
// a prefix in start-code mode sends four start-code words through the
// single output register, one per cycle unless stalled, and input is held
// meanwhile. Words pass through the input, then the output register.
// Registers (APB, 32-bit; the user writes them only while idle, which the
// block does not enforce): 0x0 length_field_bytes [2:0], reset 4, 0 acts
// as 1 and 5..7 as 4; 0x4 fragment_mode [0], reset 0.
module nal_length_prefix_to_start_code (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input stream
  input  wire logic                       s_axis_tvalid_i,
  output      logic                       s_axis_tready_o,
  input  wire logic [nlsc_pkg::ByteW-1:0] s_axis_tdata_i,  // [7:0] in_byte
  input  wire logic                       s_axis_tlast_i,  // last_of_sample
  // output stream
  output      logic                       m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output      logic [nlsc_pkg::ByteW-1:0] m_axis_tdata_o,  // [7:0] out_byte
  // [0] has_byte, [1] unit_end, [2] sample_end, [4:3] status
  output      logic [nlsc_pkg::UserW-1:0] m_axis_tuser_o,
  output      logic                       m_axis_tlast_o,  // last_of_run
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [nlsc_pkg::AddrW-1:0] paddr,
  input  wire logic [nlsc_pkg::DataW-1:0] pwdata,
  output      logic [nlsc_pkg::DataW-1:0] prdata,
  output      logic                       pready
);

  // config registers
  logic [nlsc_pkg::SizeW-1:0] size_q;
  logic                       frag_q;
  logic                       cfg_wr;
  nlsc_pkg::nlsc_reg_e        cfg_idx;

  // input register
  logic                       in_valid_q, in_valid_d;
  logic [nlsc_pkg::ByteW-1:0] in_byte_q;
  logic                       in_last_q;

  // output register
  logic                       out_valid_q, out_valid_d;
  nlsc_pkg::nlsc_res_t        out_res_q, out_res_d;
  logic                       out_lor_q, out_lor_d;
  logic                       out_load;

  // remaining start-code words still to send
  logic [1:0]                 sc_cnt_q, sc_cnt_d;

  logic                       out_free;
  logic                       sc_busy;
  logic                       step;
  nlsc_pkg::nlsc_act_e        act;
  nlsc_pkg::nlsc_res_t        res;

  // apb: always ready, word-aligned decode on paddr[2]
  assign pready  = 1'b1;
  assign cfg_idx = nlsc_pkg::nlsc_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      nlsc_pkg::REG_LENGTH_FIELD_BYTES: prdata[nlsc_pkg::SizeW-1:0] = size_q;
      nlsc_pkg::REG_FRAGMENT_MODE:      prdata[0]                   = frag_q;
      default:                          prdata                      = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= nlsc_pkg::SizeReset;
      frag_q <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_idx == nlsc_pkg::REG_LENGTH_FIELD_BYTES) begin
        size_q <= pwdata[nlsc_pkg::SizeW-1:0];
      end else begin
        frag_q <= pwdata[0];
      end
    end
  end

  // the output register frees up when empty or when its word is taken
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign sc_busy  = (sc_cnt_q != '0);
  // the held word is processed once the start-code tail is out
  assign step     = in_valid_q && !sc_busy && out_free;

  assign s_axis_tready_o = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  nlsc_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .in_byte_i       (in_byte_q),
    .last_i          (in_last_q),
    .size_cfg_i      (size_q),
    .fragment_mode_i (frag_q),
    .act_o           (act),
    .res_o           (res)
  );

  // output word selection: start-code tail first, then the parser's result
  always_comb begin
    sc_cnt_d  = sc_cnt_q;
    out_res_d = out_res_q;
    out_lor_d = out_lor_q;
    out_load  = 1'b0;
    if (sc_busy && out_free) begin
      out_load           = 1'b1;
      out_res_d          = '0;
      out_res_d.has_byte = 1'b1;
      out_res_d.out_byte = (sc_cnt_q == 2'd1) ? nlsc_pkg::ScOne : nlsc_pkg::ScZero;
      out_lor_d          = (sc_cnt_q == 2'd1);
      sc_cnt_d           = sc_cnt_q - 2'd1;
    end else if (step && (act != nlsc_pkg::ACT_NONE)) begin
      out_load  = 1'b1;
      out_res_d = res;
      out_lor_d = (act == nlsc_pkg::ACT_ONE);
      if (act == nlsc_pkg::ACT_START) begin
        sc_cnt_d = nlsc_pkg::ScTail;
      end
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = out_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sc_cnt_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      sc_cnt_q    <= sc_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= out_res_d;
      out_lor_q <= out_lor_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q.out_byte;
  assign m_axis_tuser_o  = {out_res_q.status, out_res_q.sample_end,
                            out_res_q.unit_end, out_res_q.has_byte};
  assign m_axis_tlast_o  = out_lor_q;

endmodule

`default_nettype wire

// ===== hdl/nlsc_checker.sv =====
// port-level checks for the converter, bound to the top level
`default_nettype none

module nlsc_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       m_axis_tvalid_o,
  input wire logic                       m_axis_tready_i,
  input wire logic [nlsc_pkg::ByteW-1:0] m_axis_tdata_o,
  input wire logic [nlsc_pkg::UserW-1:0] m_axis_tuser_o,
  input wire logic                       m_axis_tlast_o
);

  // a stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // marker words carry a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("marker word with non-zero byte");

  // an error status only appears on the sample's final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[4:3] != nlsc_pkg::STATUS_OK) |->
      m_axis_tuser_o[2] && m_axis_tlast_o)
    else $error("error status away from sample end");

  // sample end always closes the run of its input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[2] |-> m_axis_tlast_o)
    else $error("sample end without end of run");

endmodule

bind nal_length_prefix_to_start_code nlsc_checker u_nlsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
